/* design/mics_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mics_pkg
// shared widths, codes and sequencer states of the interval cover stream
// ----------------------------------------------------------------------------
package mics_pkg;

  localparam int REACH_W    = 10;
  localparam int LEN_W      = 10;
  localparam int COVER_W    = 12;
  localparam int COUNT_W    = 11;
  localparam int ENTRY_W    = 2 * REACH_W;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 1;
  localparam int CFG_DATA_W = LEN_W;

  // first gap marker for no gap seen
  localparam logic signed [COVER_W-1:0] NO_GAP = -12'sd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_TOP,
    S_BELOW,
    S_EMIT
  } state_t;

endpackage

/* design/min_interval_cover_stream_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_interval_cover_stream_top
// greedy minimum interval cover over a stream of reach words, with the chosen
// intervals held as a stack in one synchronous single-port-read memory
// ----------------------------------------------------------------------------
// sequence: accept (S_IDLE), then evaluate (S_EVAL); an extension that starts
//   above zero over a nonempty stack then walks the top entries in S_TOP,
//   popping dominated ones, and checks the entry below the kept top in S_BELOW,
//   each from a registered memory read; sequential: a new word is taken only in
//   S_IDLE; a last word loads the result in S_EMIT, held while the prior one waits
// reset: synchronous active-low rst_n clears sequencer, run state and out valid
module min_interval_cover_stream_top #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: garden_length
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mics_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mics_pkg::IN_DATA_W-1:0]    in_tdata,   // [9:0] tap_reach
  input  logic                              in_tlast,   // is_last
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mics_pkg::OUT_DATA_W-1:0]   out_tdata,  // [10:0] tap_count
  output logic [mics_pkg::OUT_USER_W-1:0]   out_tuser   // [0] covered
);
  import mics_pkg::*;

  localparam int IW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int SW = $clog2(MAX_POSITIONS + 1);

  typedef logic signed [COVER_W-1:0] cov_t;

  // sequencer and run state
  state_t               state_r, state_nxt;
  logic [LEN_W-1:0]     garden_length_r;
  logic [COUNT_W-1:0]   position_r, position_nxt;
  cov_t                 cover_start_r, cover_start_nxt;
  cov_t                 cover_end_r, cover_end_nxt;
  cov_t                 first_gap_r, first_gap_nxt;
  logic [SW-1:0]        stack_size_r, stack_size_nxt;

  // current word
  logic [REACH_W-1:0]   reach_r, reach_nxt;
  logic [REACH_W-1:0]   item_pos_r, item_pos_nxt;
  logic                 take_r, take_nxt;
  logic                 last_r, last_nxt;
  cov_t                 lo_r, lo_nxt;
  cov_t                 hi_r, hi_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   tap_count_r, tap_count_nxt;
  logic                 covered_r, covered_nxt;

  // stack memory
  logic [ENTRY_W-1:0]   stack_mem [MAX_POSITIONS];
  logic [ENTRY_W-1:0]   mem_rdata_r;
  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0]   mem_wdata;

  // decisions
  cov_t                 len_s;
  cov_t                 top_start, below_end;
  logic                 in_acc, out_load;
  logic                 br_reset, br_gap, br_extend;
  logic                 ext_now;
  logic                 top_dom, below_cov;
  logic                 step_done;
  logic [SW-1:0]        push_at;
  logic                 push_en;
  logic                 cover_ok;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  assign len_s = cov_t'({2'b00, garden_length_r});

  // branch choice of the evaluation step
  assign br_reset  = (cover_start_r >= lo_r);
  assign br_gap    = !br_reset && (lo_r > cover_end_r) && (first_gap_r == NO_GAP);
  assign br_extend = !br_reset && !br_gap && (hi_r > cover_end_r) &&
                     (lo_r <= cover_end_r) && (first_gap_r == NO_GAP) &&
                     (cover_end_r < len_s);
  // extension that pushes without walking the stack
  assign ext_now   = (lo_r <= 12'sd0) || (stack_size_r == '0);

  // stack entry: position in upper half, reach in lower half
  assign top_start = cov_t'({2'b00, mem_rdata_r[ENTRY_W-1:REACH_W]}) -
                     cov_t'({2'b00, mem_rdata_r[REACH_W-1:0]});
  assign below_end = cov_t'({2'b00, mem_rdata_r[ENTRY_W-1:REACH_W]}) +
                     cov_t'({2'b00, mem_rdata_r[REACH_W-1:0]});
  assign top_dom   = (lo_r <= top_start);
  assign below_cov = (below_end >= lo_r);

  assign cover_ok = !((first_gap_r != NO_GAP) || (cover_start_r > 12'sd0) ||
                      (cover_end_r < len_s));

  // step_done: the current word has finished its stack work
  always_comb begin
    step_done = 1'b0;
    case (state_r)
      S_EVAL:  step_done = !take_r || !br_extend || ext_now;
      S_TOP:   step_done = top_dom ? (stack_size_r == SW'(1))
                                   : (stack_size_r == SW'(1));
      S_BELOW: step_done = 1'b1;
      default: step_done = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_EVAL;
      S_EVAL:  begin
        if (step_done) state_nxt = last_r ? S_EMIT : S_IDLE;
        else           state_nxt = S_TOP;
      end
      S_TOP:   begin
        if (step_done)     state_nxt = last_r ? S_EMIT : S_IDLE;
        else if (!top_dom) state_nxt = S_BELOW;
      end
      S_BELOW: state_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    position_nxt    = position_r;
    cover_start_nxt = cover_start_r;
    cover_end_nxt   = cover_end_r;
    first_gap_nxt   = first_gap_r;
    stack_size_nxt  = stack_size_r;
    reach_nxt       = reach_r;
    item_pos_nxt    = item_pos_r;
    take_nxt        = take_r;
    last_nxt        = last_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    tap_count_nxt   = tap_count_r;
    covered_nxt     = covered_r;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    push_en         = 1'b0;
    push_at         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // new run on position zero
          if (position_r == '0) begin
            cover_start_nxt = len_s + 12'sd1;
            cover_end_nxt   = NO_GAP;
            first_gap_nxt   = 12'sd0;
            stack_size_nxt  = '0;
          end
          reach_nxt    = in_tdata[REACH_W-1:0];
          item_pos_nxt = position_r[REACH_W-1:0];
          lo_nxt       = cov_t'({1'b0, position_r}) -
                         cov_t'({2'b00, in_tdata[REACH_W-1:0]});
          hi_nxt       = cov_t'({1'b0, position_r}) +
                         cov_t'({2'b00, in_tdata[REACH_W-1:0]});
          take_nxt     = (position_r <= {1'b0, garden_length_r}) &&
                         (in_tdata[REACH_W-1:0] != '0);
          last_nxt     = in_tlast;
          if (position_r <= {1'b0, garden_length_r})
            position_nxt = position_r + COUNT_W'(1);
          if (in_tlast)
            position_nxt = '0;
        end
      end
      S_EVAL: begin
        if (take_r) begin
          if (br_reset) begin
            cover_start_nxt = lo_r;
            cover_end_nxt   = hi_r;
            push_en         = 1'b1;
            push_at         = '0;
            if (lo_r <= first_gap_r) first_gap_nxt = NO_GAP;
          end else if (br_gap) begin
            first_gap_nxt = cover_end_r;
          end else if (br_extend) begin
            cover_end_nxt = (hi_r < len_s) ? hi_r : len_s;
            if (lo_r <= 12'sd0) begin
              push_en = 1'b1;
              push_at = '0;
            end else if (stack_size_r == '0) begin
              push_en = 1'b1;
              push_at = '0;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = IW'(stack_size_r - SW'(1));
            end
          end
        end
      end
      S_TOP: begin
        if (top_dom) begin
          // dominated top: pop and look at the next one down
          if (stack_size_r == SW'(1)) begin
            push_en = 1'b1;
            push_at = '0;
          end else begin
            stack_size_nxt = stack_size_r - SW'(1);
            mem_re         = 1'b1;
            mem_raddr      = IW'(stack_size_r - SW'(2));
          end
        end else if (stack_size_r == SW'(1)) begin
          // single kept entry stays
          push_en = 1'b1;
          push_at = stack_size_r;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(stack_size_r - SW'(2));
        end
      end
      S_BELOW: begin
        // kept top is redundant when the entry below reaches our start
        push_en = 1'b1;
        push_at = below_cov ? (stack_size_r - SW'(1)) : stack_size_r;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          covered_nxt   = cover_ok;
          tap_count_nxt = cover_ok ? COUNT_W'(stack_size_r) : '0;
        end
      end
      default: begin
      end
    endcase

    // push of the current interval, dropped on a full stack
    if (push_en) begin
      if (push_at < SW'(MAX_POSITIONS)) stack_size_nxt = push_at + SW'(1);
      else                              stack_size_nxt = push_at;
    end
  end

  assign mem_we    = push_en && (push_at < SW'(MAX_POSITIONS));
  assign mem_waddr = IW'(push_at);
  assign mem_wdata = {item_pos_r, reach_r};

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= stack_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      garden_length_r <= LEN_W'(1);
      position_r      <= '0;
      cover_start_r   <= 12'sd2;
      cover_end_r     <= NO_GAP;
      first_gap_r     <= 12'sd0;
      stack_size_r    <= '0;
      take_r          <= 1'b0;
      last_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_valid && cfg_ready) garden_length_r <= cfg_data;
      position_r    <= position_nxt;
      cover_start_r <= cover_start_nxt;
      cover_end_r   <= cover_end_nxt;
      first_gap_r   <= first_gap_nxt;
      stack_size_r  <= stack_size_nxt;
      take_r        <= take_nxt;
      last_r        <= last_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // word payload and result data, no reset
  always_ff @(posedge clk) begin
    reach_r     <= reach_nxt;
    item_pos_r  <= item_pos_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    tap_count_r <= tap_count_nxt;
    covered_r   <= covered_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(tap_count_r);
  assign out_tuser  = covered_r;

  // checks
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_size_r <= SW'(MAX_POSITIONS))
    else $error("stack size above depth");

  a_top_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TOP) |-> (stack_size_r != '0))
    else $error("top read on empty stack");

  a_below_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BELOW) |-> (stack_size_r >= SW'(2)))
    else $error("below check without two entries");

  a_read_then_use: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> ((state_r == S_TOP) || (state_r == S_BELOW)))
    else $error("stack read not consumed");

  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_EMIT) && (state_nxt == S_EMIT)) |-> last_r)
    else $error("result without last word");

endmodule
